// ===== hw/rtl/soft_clip_overdrive_defines.svh =====
// Assertion macros for the soft-clip overdrive block.
// Assumes the asserting module has a clock named clk and an active-low reset arst_n.
`ifndef SOFT_CLIP_OVERDRIVE_DEFINES_SVH
`define SOFT_CLIP_OVERDRIVE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define SCO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside of reset.
`define SCO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sco_pkg.sv =====
// Shared types and constants for the soft-clip overdrive block.
// No dependencies.
`timescale 1ns / 1ps

package sco_pkg;

	// Sample format: signed, one integer bit, 23 fraction bits.
	localparam int SAMPLE_W = 24;
	localparam int FRAC     = 23;

	// Configuration register widths and indexes.
	localparam int GAIN_W  = 16;
	localparam int COEF_W  = 24;
	localparam int VOL_W   = 16;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LP_A0     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LP_B1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LP_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 3'd5;

	// Shared multiplier: signed operands, wide enough for every product.
	localparam int MUL_W  = 29;
	localparam int PROD_W = 2 * MUL_W;

	// Internal value widths.
	localparam int X_W   = 32;  // gained sample, Q9.23
	localparam int D_W   = 27;  // 2 - 3|x| in the middle region
	localparam int MAG_W = 27;  // |3 - d^2|
	localparam int QUO_W = 26;  // |3 - d^2| / 3
	localparam int V_W   = 28;  // shaped value and lowpass state, Q5.23
	localparam int ACC_W = 53;  // one lowpass product
	localparam int SUM_W = 54;  // sum of both lowpass products

	// Fixed-point constants.
	localparam logic signed [V_W-1:0] ONE_Q   = 28'sh0800000;
	localparam logic signed [D_W-1:0] TWO_Q   = 27'sh1000000;
	localparam logic signed [MAG_W+1:0] THREE_Q = 29'sd25165824;

	// floor(m / 3) = (m * RECIP3) >> RECIP3_SH, exact for m below 2^29.
	localparam int RECIP3_W  = 28;
	localparam int RECIP3_SH = 29;
	localparam logic [RECIP3_W-1:0] RECIP3 = 28'd178956971;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd256;
	localparam logic [COEF_W-1:0] THRESHOLD_RST = 24'd2796203;
	localparam logic [COEF_W-1:0] LP_A0_RST     = 24'd8388608;
	localparam logic [COEF_W-1:0] LP_B1_RST     = 24'd0;
	localparam logic [VOL_W-1:0]  VOLUME_RST    = 16'd4096;

endpackage

// ===== hw/rtl/soft_clip_overdrive.sv =====
// Soft-clip overdrive: drive gain, three-region waveshaper, one-pole lowpass, volume.
// Depends on sco_pkg and on soft_clip_overdrive_defines.svh for its assertions.
//
//  Channel   Direction  Ports                                 Contents
//  s_*       in         s_tvalid s_tready s_tdata[23:0]       sample_in
//  m_*       out        m_tvalid m_tready m_tdata[23:0]       sample_out
//  cfg_*     in         cfg_we cfg_index[2:0] cfg_data[23:0]  register writes
//
// A sample goes through gain, the waveshaper, the lowpass steps unless the lowpass is
// bypassed, and volume; the middle region adds the squaring and the division by three.
// A new sample is accepted only once the last one has finished. Every product
// goes through one shared 29 x 29 signed multiplier, one product per cycle.
// Reset is asynchronous and active low; it restores the
// register defaults and clears the lowpass state. A stalled output holds the sequencer
// in its last step while the finished result waits in the output register.
`timescale 1ns / 1ps

`include "soft_clip_overdrive_defines.svh"

module soft_clip_overdrive
	import sco_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SAMPLE_W-1:0]  s_tdata,   // [23:0] sample_in
	// Output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [SAMPLE_W-1:0]  m_tdata,   // [23:0] sample_out
	// Configuration writes.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// The sequencer walks through the steps below. Each step that starts with a
	// multiplication drives the shared multiplier; the step after it consumes the
	// registered product.
	typedef enum logic [3:0] {
		ST_IDLE,   // waiting for a sample
		ST_GAIN,   // sample * gain
		ST_SHAPE,  // region decision, linear and outer values, middle-region d
		ST_SQ,     // d * d
		ST_NUM,    // 3 - d^2 and its magnitude
		ST_DIV,    // magnitude * reciprocal of three
		ST_QUO,    // quotient with its sign
		ST_LPA,    // a0 * v
		ST_LPB,    // b1 * y, while a0 * v is set aside
		ST_LPS,    // lowpass sum, rescale and saturate
		ST_VOL,    // w * volume
		ST_OUT     // rescale, saturate, hand to the output register
	} state_t;

	// Configuration registers.
	logic [GAIN_W-1:0] gain_q;
	logic [COEF_W-1:0] thr_q;
	logic [COEF_W-1:0] a0_q;
	logic [COEF_W-1:0] b1_q;
	logic              lp_en_q;
	logic [VOL_W-1:0]  vol_q;

	// Datapath and control registers.
	state_t                     state_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [D_W-1:0]      d_q;
	logic [MAG_W-1:0]           mag_q;
	logic                       neg_q;
	logic signed [V_W-1:0]      v_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [V_W-1:0]      y_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_valid_q;

	// Combinational signals.
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [X_W-1:0]    x;
	logic                     x_neg;
	logic [X_W-1:0]           x_mag;
	logic                     in_lin;
	logic                     in_mid;
	logic [D_W-2:0]           a3;
	logic signed [D_W-1:0]    d_next;
	logic [MAG_W-1:0]         sq;
	logic signed [MAG_W+1:0]  num;
	logic [MAG_W+1:0]         num_abs;
	logic [QUO_W-1:0]         quo;
	logic signed [V_W-1:0]    quo_s;
	logic signed [V_W-1:0]    v_shape;
	logic signed [SUM_W-1:0]  lp_sum;
	logic signed [V_W-1:0]    y_next;
	logic signed [V_W-1:0]    w;
	logic signed [X_W-1:0]    r;
	logic [SAMPLE_W-1:0]      r_sat;
	logic                     s_acc;
	logic                     out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The result may enter the output register once the previous one has gone.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// Configuration writes. Indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			thr_q   <= THRESHOLD_RST;
			a0_q    <= LP_A0_RST;
			b1_q    <= LP_B1_RST;
			lp_en_q <= 1'b1;
			vol_q   <= VOLUME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:      gain_q  <= cfg_data[GAIN_W-1:0];
				REG_THRESHOLD: thr_q   <= cfg_data[COEF_W-1:0];
				REG_LP_A0:     a0_q    <= cfg_data[COEF_W-1:0];
				REG_LP_B1:     b1_q    <= cfg_data[COEF_W-1:0];
				REG_LP_ENABLE: lp_en_q <= cfg_data[0];
				REG_VOLUME:    vol_q   <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	// The value that feeds the volume step: lowpass state or the shaped value.
	assign w = lp_en_q ? y_q : v_q;

	// Operand selection for the shared multiplier. Unsigned quantities are
	// zero-extended so that one signed multiplier serves every product.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_GAIN: begin
				op_a = MUL_W'(samp_q);
				op_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_q});
			end
			ST_SQ: begin
				op_a = MUL_W'(d_q);
				op_b = MUL_W'(d_q);
			end
			ST_DIV: begin
				op_a = $signed({{(MUL_W-MAG_W){1'b0}}, mag_q});
				op_b = $signed({{(MUL_W-RECIP3_W){1'b0}}, RECIP3});
			end
			ST_LPA: begin
				op_a = $signed({{(MUL_W-COEF_W){1'b0}}, a0_q});
				op_b = MUL_W'(v_q);
			end
			ST_LPB: begin
				op_a = $signed({{(MUL_W-COEF_W){1'b0}}, b1_q});
				op_b = MUL_W'(y_q);
			end
			ST_VOL: begin
				op_a = $signed({{(MUL_W-VOL_W){1'b0}}, vol_q});
				op_b = MUL_W'(w);
			end
			default: ;
		endcase
	end

	assign mul_p = op_a * op_b;

	// Waveshaper. x = floor(sample * gain / 2^8) keeps 23 fraction bits. The
	// arithmetic shift of the registered product is the floor.
	always_comb begin
		x      = prod_q[X_W+7:8];
		x_neg  = x[X_W-1];
		x_mag  = x_neg ? (X_W'(0) - $unsigned(x)) : $unsigned(x);
		in_lin = x_mag < {{(X_W-COEF_W){1'b0}}, thr_q};
		in_mid = x_mag < {{(X_W-COEF_W-1){1'b0}}, thr_q, 1'b0};

		// In the middle region |x| is below twice the threshold; only its low 24 bits are used, so 3|x| fits in 26 bits.
		a3     = {2'b00, x_mag[23:0]} + {1'b0, x_mag[23:0], 1'b0};
		d_next = TWO_Q - $signed({1'b0, a3});

		// Linear region doubles x; the outer region gives plus or minus one,
		// with zero counted as positive. Neither can reach the Q5.23 bounds.
		if (in_lin) begin
			v_shape = {x[V_W-2:0], 1'b0};
		end else begin
			v_shape = x_neg ? -ONE_Q : ONE_Q;
		end

		// d^2 is never negative and stays below 2^50.
		sq      = prod_q[MAG_W+FRAC-1:FRAC];
		num     = THREE_Q - $signed({2'b00, sq});
		num_abs = num[MAG_W+1] ? ((MAG_W+2)'(0) - $unsigned(num)) : $unsigned(num);

		// Division by three truncates toward zero, so the sign goes on afterwards.
		quo   = prod_q[RECIP3_SH+QUO_W-1:RECIP3_SH];
		quo_s = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	end

	// Lowpass: y = floor((a0*v + b1*y) / 2^23), saturated to Q5.23.
	always_comb begin
		lp_sum = $signed({acc_q[ACC_W-1], acc_q}) + prod_q[SUM_W-1:0];
		if (lp_sum[SUM_W-1:FRAC+V_W-1] != {(SUM_W-FRAC-V_W+1){lp_sum[SUM_W-1]}}) begin
			y_next = lp_sum[SUM_W-1] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
		end else begin
			y_next = lp_sum[FRAC+V_W-1:FRAC];
		end
	end

	// Volume: floor(w * volume / 2^12), saturated to the sample range.
	always_comb begin
		r = prod_q[X_W+11:12];
		if (r[X_W-1:SAMPLE_W-1] != {(X_W-SAMPLE_W+1){r[X_W-1]}}) begin
			r_sat = r[X_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			r_sat = r[SAMPLE_W-1:0];
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			y_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						samp_q  <= s_tdata;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					prod_q  <= mul_p;
					state_q <= ST_SHAPE;
				end
				ST_SHAPE: begin
					v_q   <= v_shape;
					d_q   <= d_next;
					neg_q <= x_neg;
					if (!in_lin && in_mid) begin
						state_q <= ST_SQ;
					end else if (lp_en_q) begin
						state_q <= ST_LPA;
					end else begin
						state_q <= ST_VOL;
					end
				end
				ST_SQ: begin
					prod_q  <= mul_p;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					mag_q   <= num_abs[MAG_W-1:0];
					neg_q   <= neg_q ^ num[MAG_W+1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					prod_q  <= mul_p;
					state_q <= ST_QUO;
				end
				ST_QUO: begin
					v_q     <= quo_s;
					state_q <= lp_en_q ? ST_LPA : ST_VOL;
				end
				ST_LPA: begin
					prod_q  <= mul_p;
					state_q <= ST_LPB;
				end
				ST_LPB: begin
					acc_q   <= prod_q[ACC_W-1:0];
					prod_q  <= mul_p;
					state_q <= ST_LPS;
				end
				ST_LPS: begin
					y_q     <= y_next;
					state_q <= ST_VOL;
				end
				ST_VOL: begin
					prod_q  <= mul_p;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_data_q <= r_sat;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A sample taken in always starts the gain multiplication next.
	`SCO_ASSERT_NEXT(a_accept_starts, s_acc, state_q == ST_GAIN, "accepted sample did not start")

	// The first and last lowpass steps must only run with the lowpass switched on.
	`SCO_ASSERT_NOW(a_lp_enabled, (state_q == ST_LPA) || (state_q == ST_LPS), lp_en_q, "lowpass ran while bypassed")

	// Finishing a sample always leaves a result waiting at the output.
	`SCO_ASSERT_NEXT(a_result_shown, out_load, m_tvalid && (state_q == ST_IDLE), "finished sample not presented")

endmodule
